FILE: hw/rtl/dwp_pkg.sv
// dwp_pkg: shared widths, codes, register map, config struct and pipeline control
// struct for the dual wheel pid block; no dependencies
package dwp_pkg;

	localparam int SPEED_W       = 16;
	localparam int ERR_W         = 17;
	localparam int GAIN_W        = 16;
	localparam int DUTY_W        = 14;
	localparam int STEER_W       = 32;
	localparam int TAP_W         = 32;
	localparam int SAT_W         = 50;
	localparam int DUTY_MIN      = 0;
	localparam int DUTY_MAX      = 10000;
	localparam int TAP_COUNT_DEF = 3;
	localparam int NSTG          = 8;
	localparam int RECIP_SH      = 24;
	localparam int APB_AW        = 5;
	localparam int APB_DW        = 32;

	typedef enum logic {
		CMD_STEER = 1'b0,
		CMD_SPEED = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TARGET_SPEED,
		REG_SPEED_KP,
		REG_SPEED_KI,
		REG_SPEED_KD,
		REG_STEER_KP,
		REG_STEER_KI,
		REG_STEER_KD,
		REG_COUPLING
	} reg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] target_speed;
		logic [GAIN_W-1:0]  speed_kp;
		logic [GAIN_W-1:0]  speed_ki;
		logic [GAIN_W-1:0]  speed_kd;
		logic [GAIN_W-1:0]  steer_kp;
		logic [GAIN_W-1:0]  steer_ki;
		logic [GAIN_W-1:0]  steer_kd;
		logic               coupling_enable;
	} cfg_t;

	// bit k of spd/str: a speed or steer beat sits in stage k (bit 0 is the accept)
	typedef struct packed {
		logic            en;
		logic [NSTG:0]   spd;
		logic [NSTG:0]   str;
	} pipe_ctl_t;

	function automatic logic signed [STEER_W-1:0] sat_to32(input logic signed [SAT_W-1:0] v);
		logic signed [STEER_W-1:0] r;
		if (v > SAT_W'(64'sd2147483647)) begin
			r = 32'sh7fffffff;
		end else if (v < -SAT_W'(64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = v[STEER_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/dwp_ifs.sv
// dwp_item_if and dwp_result_if: valid/ready channels for input and result beats
// depends on dwp_pkg for field widths
interface dwp_item_if;
	import dwp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic signed [SPEED_W-1:0] steer_error;

	modport source(output valid, cmd, left_speed, right_speed, steer_error, input ready);
	modport sink(input valid, cmd, left_speed, right_speed, steer_error, output ready);
endinterface

interface dwp_result_if;
	import dwp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [DUTY_W-1:0]         left_duty;
	logic [DUTY_W-1:0]         right_duty;
	logic signed [STEER_W-1:0] steer_output;

	modport source(output valid, left_duty, right_duty, steer_output, input ready);
	modport sink(input valid, left_duty, right_duty, steer_output, output ready);
endinterface

FILE: hw/rtl/dwp_lane.sv
// dwp_lane: one wheel lane, incremental pid, coupling, tap filter, average and clamp
// depends on dwp_pkg
module dwp_lane #(
	parameter int TAP_COUNT = dwp_pkg::TAP_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwp_pkg::pipe_ctl_t                 ctl,
	input  dwp_pkg::cfg_t                      cfg,
	input  logic signed [dwp_pkg::SPEED_W-1:0] speed,
	input  logic signed [dwp_pkg::STEER_W-1:0] steer_out,
	output logic [dwp_pkg::DUTY_W-1:0]         duty_s8
);
	import dwp_pkg::*;

	localparam int PKP_W   = ERR_W + 1 + GAIN_W + 1;
	localparam int PKI_W   = ERR_W + GAIN_W + 1;
	localparam int PKD_W   = ERR_W + 2 + GAIN_W + 1;
	localparam int Q_W     = PKD_W + 1;
	localparam int INC_W   = Q_W - 8;
	localparam int INCC_W  = STEER_W + 2;
	localparam int TSUM_W  = TAP_W + $clog2(TAP_COUNT);
	localparam int SUM_CAP = (DUTY_MAX + 1) * TAP_COUNT;
	localparam int DIV_W   = $clog2(SUM_CAP);
	localparam int RECIP_W = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + TAP_COUNT - 1) / TAP_COUNT);
	localparam int PROD_W  = (DIV_W + RECIP_W > RECIP_SH + DUTY_W) ?
		DIV_W + RECIP_W : RECIP_SH + DUTY_W;

	logic signed [ERR_W-1:0]   last_q, prev_q, e, e_s1;
	logic signed [ERR_W:0]     d1, d1_s1;
	logic signed [ERR_W+1:0]   d2, d2_s1;
	logic signed [GAIN_W:0]    kp, ki, kd;
	logic signed [PKP_W-1:0]   pkp_s2;
	logic signed [PKI_W-1:0]   pki_s2;
	logic signed [PKD_W-1:0]   pkd_s2;
	logic signed [Q_W-1:0]     q_s3, qa;
	logic signed [INC_W-1:0]   inc;
	logic signed [INCC_W-1:0]  cpl, inc_s4;
	logic signed [TAP_W-1:0]   taps_q [TAP_COUNT];
	logic signed [TAP_W-1:0]   tap_new;
	logic signed [TSUM_W-1:0]  tsum, tsum_s6;
	logic                      neg_s7, hi_s7;
	logic [PROD_W-1:0]         prod_s7;
	logic [DUTY_W-1:0]         quot, duty;

	assign kp = $signed({1'b0, cfg.speed_kp});
	assign ki = $signed({1'b0, cfg.speed_ki});
	assign kd = $signed({1'b0, cfg.speed_kd});

	// speed error and the two differences of the incremental form
	always_comb begin
		e  = ERR_W'($signed(cfg.target_speed)) - ERR_W'(speed);
		d1 = (ERR_W+1)'(e) - (ERR_W+1)'(last_q);
		d2 = (ERR_W+2)'(e) + (ERR_W+2)'(prev_q) - ((ERR_W+2)'(last_q) <<< 1);
	end

	// q8.8 to integer rounding toward zero, then coupling
	always_comb begin
		qa  = q_s3[Q_W-1] ? q_s3 + Q_W'(255) : q_s3;
		inc = qa[Q_W-1:8];
		cpl = cfg.coupling_enable ? INCC_W'(steer_out) : INCC_W'(0);
	end

	assign tap_new = sat_to32(SAT_W'(taps_q[TAP_COUNT-1]) + SAT_W'(inc_s4));

	always_comb begin
		tsum = '0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			tsum = tsum + TSUM_W'(taps_q[i]);
		end
	end

	// negative sums land on the low bound, large ones on the high bound
	always_comb begin
		quot = prod_s7[RECIP_SH +: DUTY_W];
		if (neg_s7) begin
			duty = DUTY_W'(DUTY_MIN);
		end else if (hi_s7) begin
			duty = DUTY_W'(DUTY_MAX);
		end else if (quot < DUTY_W'(DUTY_MIN)) begin
			duty = DUTY_W'(DUTY_MIN);
		end else begin
			duty = quot;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			e_s1    <= e;
			d1_s1   <= d1;
			d2_s1   <= d2;
			pkp_s2  <= PKP_W'(d1_s1) * PKP_W'(kp);
			pki_s2  <= PKI_W'(e_s1) * PKI_W'(ki);
			pkd_s2  <= PKD_W'(d2_s1) * PKD_W'(kd);
			q_s3    <= Q_W'(pkp_s2) + Q_W'(pki_s2) + Q_W'(pkd_s2);
			inc_s4  <= INCC_W'(inc) - cpl;
			tsum_s6 <= tsum;
			neg_s7  <= tsum_s6[TSUM_W-1];
			hi_s7   <= (tsum_s6 >= TSUM_W'(SUM_CAP));
			prod_s7 <= PROD_W'(tsum_s6[DIV_W-1:0]) * PROD_W'(RECIP);
			duty_s8 <= duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			prev_q <= '0;
			for (int i = 0; i < TAP_COUNT; i++) begin
				taps_q[i] <= '0;
			end
		end else if (ctl.en) begin
			if (ctl.spd[0]) begin
				prev_q <= last_q;
				last_q <= e;
			end
			if (ctl.spd[4]) begin
				for (int i = 0; i < TAP_COUNT - 1; i++) begin
					taps_q[i] <= taps_q[i+1];
				end
				taps_q[TAP_COUNT-1] <= tap_new;
			end
		end
	end

endmodule

FILE: hw/rtl/dwp_steer.sv
// dwp_steer: positional steering pid with saturating error sum and held output
// depends on dwp_pkg
module dwp_steer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwp_pkg::pipe_ctl_t                 ctl,
	input  dwp_pkg::cfg_t                      cfg,
	input  logic signed [dwp_pkg::SPEED_W-1:0] steer_error,
	output logic signed [dwp_pkg::STEER_W-1:0] steer_out
);
	import dwp_pkg::*;

	localparam int D_W   = SPEED_W + 1;
	localparam int PKP_W = SPEED_W + GAIN_W + 1;
	localparam int PKI_W = STEER_W + GAIN_W + 1;
	localparam int PKD_W = D_W + GAIN_W + 1;
	localparam int Q_W   = SAT_W;

	logic signed [STEER_W-1:0] err_sum_q, sum_new, sum_s1, steer_out_q, out_new;
	logic signed [SPEED_W-1:0] last_err_q, err_s1;
	logic signed [D_W-1:0]     d, d_s1;
	logic signed [GAIN_W:0]    kp, ki, kd;
	logic signed [PKP_W-1:0]   pkp_s2;
	logic signed [PKI_W-1:0]   pki_s2;
	logic signed [PKD_W-1:0]   pkd_s2;
	logic signed [Q_W-1:0]     q_s3, qa;

	assign kp = $signed({1'b0, cfg.steer_kp});
	assign ki = $signed({1'b0, cfg.steer_ki});
	assign kd = $signed({1'b0, cfg.steer_kd});

	always_comb begin
		sum_new = sat_to32(SAT_W'(err_sum_q) + SAT_W'(steer_error));
		d       = D_W'(steer_error) - D_W'(last_err_q);
		qa      = q_s3[Q_W-1] ? q_s3 + Q_W'(255) : q_s3;
		out_new = sat_to32(SAT_W'($signed(qa[Q_W-1:8])));
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			err_s1 <= steer_error;
			sum_s1 <= sum_new;
			d_s1   <= d;
			pkp_s2 <= PKP_W'(err_s1) * PKP_W'(kp);
			pki_s2 <= PKI_W'(sum_s1) * PKI_W'(ki);
			pkd_s2 <= PKD_W'(d_s1) * PKD_W'(kd);
			q_s3   <= Q_W'(pkp_s2) + Q_W'(pki_s2) + Q_W'(pkd_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q   <= '0;
			last_err_q  <= '0;
			steer_out_q <= '0;
		end else if (ctl.en) begin
			if (ctl.str[0]) begin
				err_sum_q  <= sum_new;
				last_err_q <= steer_error;
			end
			if (ctl.str[3]) begin
				steer_out_q <= out_new;
			end
		end
	end

	assign steer_out = steer_out_q;

endmodule

FILE: hw/rtl/dwp_merge.sv
// dwp_merge: joins both lane duties and the steer output into the result register
// depends on dwp_pkg and dwp_result_if
module dwp_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwp_pkg::pipe_ctl_t                 ctl,
	input  logic [dwp_pkg::DUTY_W-1:0]         left_duty_s8,
	input  logic [dwp_pkg::DUTY_W-1:0]         right_duty_s8,
	input  logic signed [dwp_pkg::STEER_W-1:0] steer_out,
	dwp_result_if.source                       result,
	output logic                               en
);
	import dwp_pkg::*;

	logic                      vld_q;
	logic [DUTY_W-1:0]         left_q, right_q;
	logic signed [STEER_W-1:0] steer_q;
	logic signed [STEER_W-1:0] steer_s5, steer_s6, steer_s7, steer_s8;

	assign en = !vld_q || result.ready;

	// steer value sampled once every earlier steer beat has written it
	always_ff @(posedge clk) begin
		if (en) begin
			steer_s5 <= steer_out;
			steer_s6 <= steer_s5;
			steer_s7 <= steer_s6;
			steer_s8 <= steer_s7;
			if (ctl.spd[NSTG] || ctl.str[NSTG]) begin
				steer_q <= steer_s8;
			end
		end
	end

	// duty registers double as the held duties for steer beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			left_q  <= '0;
			right_q <= '0;
		end else if (en) begin
			vld_q <= ctl.spd[NSTG] || ctl.str[NSTG];
			if (ctl.spd[NSTG]) begin
				left_q  <= left_duty_s8;
				right_q <= right_duty_s8;
			end
		end
	end

	assign result.valid        = vld_q;
	assign result.left_duty    = left_q;
	assign result.right_duty   = right_q;
	assign result.steer_output = steer_q;

endmodule

FILE: hw/rtl/dual_wheel_incremental_pid_with_steer.sv
// dual_wheel_incremental_pid_with_steer: top level, config registers, beat tracking
// depends on dwp_pkg, dwp_ifs, dwp_lane, dwp_steer, dwp_merge
//
//   channel   dir   handshake             carries
//   item      in    valid/ready           cmd, left_speed, right_speed, steer_error
//   result    out   valid/ready           left_duty, right_duty, steer_output
//   apb       in    psel/penable/pready   8 registers at byte address 4*index
//
// one beat per cycle sustained while results are taken; the edge that takes a beat
// loads stage register s1, then it passes s2 to s8, a depth set by the lane
// multipliers and the tap average, and then the result register
// reset clears filter, error, duty and steer loop state at once; no clearing pass
// a result that is not taken freezes every stage and drops item ready
module dual_wheel_incremental_pid_with_steer #(
	parameter int TAP_COUNT = dwp_pkg::TAP_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dwp_item_if.sink                     item,
	dwp_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dwp_pkg::APB_AW-1:0]   paddr,
	input  logic [dwp_pkg::APB_DW-1:0]   pwdata,
	output logic [dwp_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import dwp_pkg::*;

	cfg_t                      cfg_q;
	pipe_ctl_t                 ctl;
	logic                      en, accept;
	logic [NSTG:1]             spd_q, str_q;
	logic [DUTY_W-1:0]         left_duty_s8, right_duty_s8;
	logic signed [STEER_W-1:0] steer_out;
	reg_idx_t                  ridx;

	assign ridx   = reg_idx_t'(paddr[APB_AW-1:2]);
	assign pready = 1'b1;

	// register writes land on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_TARGET_SPEED: cfg_q.target_speed    <= pwdata[SPEED_W-1:0];
				REG_SPEED_KP:     cfg_q.speed_kp        <= pwdata[GAIN_W-1:0];
				REG_SPEED_KI:     cfg_q.speed_ki        <= pwdata[GAIN_W-1:0];
				REG_SPEED_KD:     cfg_q.speed_kd        <= pwdata[GAIN_W-1:0];
				REG_STEER_KP:     cfg_q.steer_kp        <= pwdata[GAIN_W-1:0];
				REG_STEER_KI:     cfg_q.steer_ki        <= pwdata[GAIN_W-1:0];
				REG_STEER_KD:     cfg_q.steer_kd        <= pwdata[GAIN_W-1:0];
				REG_COUPLING:     cfg_q.coupling_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_TARGET_SPEED: prdata = APB_DW'(cfg_q.target_speed);
			REG_SPEED_KP:     prdata = APB_DW'(cfg_q.speed_kp);
			REG_SPEED_KI:     prdata = APB_DW'(cfg_q.speed_ki);
			REG_SPEED_KD:     prdata = APB_DW'(cfg_q.speed_kd);
			REG_STEER_KP:     prdata = APB_DW'(cfg_q.steer_kp);
			REG_STEER_KI:     prdata = APB_DW'(cfg_q.steer_ki);
			REG_STEER_KD:     prdata = APB_DW'(cfg_q.steer_kd);
			REG_COUPLING:     prdata = APB_DW'(cfg_q.coupling_enable);
			default:          prdata = '0;
		endcase
	end

	// the whole pipe moves together whenever the result register can take a beat
	assign item.ready = en;
	assign accept     = item.valid && en;

	always_comb begin
		ctl.en  = en;
		ctl.spd = {spd_q, accept && (item.cmd == CMD_SPEED)};
		ctl.str = {str_q, accept && (item.cmd == CMD_STEER)};
	end

	// per-stage occupancy, split by beat kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q <= '0;
			str_q <= '0;
		end else if (en) begin
			spd_q <= ctl.spd[NSTG-1:0];
			str_q <= ctl.str[NSTG-1:0];
		end
	end

	// steer loop writes its output at stage 3; lanes read it for coupling at stage 3
	dwp_steer u_steer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.steer_error (item.steer_error),
		.steer_out   (steer_out)
	);

	dwp_lane #(.TAP_COUNT(TAP_COUNT)) u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg_q),
		.speed     (item.left_speed),
		.steer_out (steer_out),
		.duty_s8   (left_duty_s8)
	);

	dwp_lane #(.TAP_COUNT(TAP_COUNT)) u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg_q),
		.speed     (item.right_speed),
		.steer_out (steer_out),
		.duty_s8   (right_duty_s8)
	);

	dwp_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.left_duty_s8  (left_duty_s8),
		.right_duty_s8 (right_duty_s8),
		.steer_out     (steer_out),
		.result        (result),
		.en            (en)
	);

endmodule

FILE: hw/rtl/dwp_checker.sv
// dwp_checker: port level assertions for the dual wheel pid block, bound to the top
// depends on dwp_pkg
module dwp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic [dwp_pkg::DUTY_W-1:0]        left_duty,
	input logic [dwp_pkg::DUTY_W-1:0]        right_duty,
	input logic signed [dwp_pkg::STEER_W-1:0] steer_output,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [dwp_pkg::APB_AW-1:0]        paddr,
	input logic [dwp_pkg::APB_DW-1:0]        pwdata,
	input logic [dwp_pkg::APB_DW-1:0]        prdata
);
	import dwp_pkg::*;

	localparam logic [APB_AW-1:0] CPL_ADDR = {REG_COUPLING, 2'b00};

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(left_duty) && $stable(right_duty) && $stable(steer_output))
		else $error("result beat changed while stalled");

	// a stalled result must block new input beats
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input taken while result stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> left_duty <= DUTY_W'(DUTY_MAX) && right_duty <= DUTY_W'(DUTY_MAX))
		else $error("duty above upper bound");

	// coupling bit reads back what was just written
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite && paddr == CPL_ADDR)
			&& psel && !pwrite && paddr == CPL_ADDR |-> prdata[0] == $past(pwdata[0]))
		else $error("coupling readback mismatch");

endmodule

bind dual_wheel_incremental_pid_with_steer dwp_checker u_dwp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.left_duty    (result.left_duty),
	.right_duty   (result.right_duty),
	.steer_output (result.steer_output),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

FILE: dv/dual_wheel_incremental_pid_with_steer_tb.sv
// dual_wheel_incremental_pid_with_steer_tb: self-checking bench for the dual wheel pid block
// drives item beats and apb register writes, predicts every result and checks it per field
// depends on dwp_pkg, dwp_ifs and the rtl top level
module dual_wheel_incremental_pid_with_steer_tb;
	import dwp_pkg::*;

	// sizes the final wait for stray results
	localparam int RESULT_LATENCY = 8;
	// cycles with no beat, result or register write before giving up
	localparam int STALL_LIMIT    = 2000;
	// long receiver hold-off so the pipeline backs up into the input
	localparam int PRESSURE_HOLD  = 80;
	// keep the log short once things go wrong
	localparam int REPORT_CAP     = 50;
	localparam int PHASE_BEATS    = 40;
	localparam int RANDOM_PHASES  = 5;
	// full-scale steer beats: enough to pin the steer output at the top rail
	localparam int WIND_UP_BEATS   = 300;
	localparam int WIND_DOWN_BEATS = 8;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		cmd_t                      cmd;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic signed [SPEED_W-1:0] steer_error;
	} beat_t;

	typedef struct {
		logic [DUTY_W-1:0]         left_duty;
		logic [DUTY_W-1:0]         right_duty;
		logic signed [STEER_W-1:0] steer_output;
	} ctl_out_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	dwp_item_if   beat_bus ();
	dwp_result_if out_bus ();

	dual_wheel_incremental_pid_with_steer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(beat_bus),
		.result(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// controller shadow: register copy plus all loop state, index 0 left wheel, 1 right
	cfg_t                      cfg;
	logic signed [ERR_W-1:0]   last_err [2];
	logic signed [ERR_W-1:0]   err_prev [2];
	logic signed [TAP_W-1:0]   taps [2][TAP_COUNT_DEF];
	logic [DUTY_W-1:0]         duty [2];
	logic signed [STEER_W-1:0] steer_sum;
	logic signed [STEER_W-1:0] steer_out;
	logic signed [SPEED_W-1:0] steer_last;

	beat_t    beats_to_send [$];
	ctl_out_t predicted_out [$];

	bit beat_offered  = 0;
	bit full_rate     = 0;
	bit pressure_req  = 0;
	int send_gap      = 0;
	int send_calm     = 0;
	int sink_stall    = 0;
	int sink_calm     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int mismatches    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [STEER_W-1:0] clip32(longint v);
		if (v > S32_MAX)
			return 32'sh7fffffff;
		if (v < S32_MIN)
			return 32'sh80000000;
		return v[STEER_W-1:0];
	endfunction

	// incremental pid for one wheel, then the tap filter and the duty clamp
	function automatic void wheel_step(int w, logic signed [SPEED_W-1:0] speed);
		longint e, last, prev, kp, ki, kd, q, inc, acc;
		e    = longint'($signed(cfg.target_speed)) - longint'(speed);
		last = last_err[w];
		prev = err_prev[w];
		kp   = cfg.speed_kp;
		ki   = cfg.speed_ki;
		kd   = cfg.speed_kd;
		q    = kp * (e - last) + ki * e + kd * (e + prev - 2 * last);
		// q8.8 back to counts, truncating toward zero
		inc  = q / 256;
		err_prev[w] = last_err[w];
		last_err[w] = e[ERR_W-1:0];
		if (cfg.coupling_enable)
			inc = inc - longint'(steer_out);
		// oldest tap drops out, newest tap keeps its value and takes the increment
		for (int i = 0; i < TAP_COUNT_DEF - 1; i++)
			taps[w][i] = taps[w][i + 1];
		taps[w][TAP_COUNT_DEF - 1] = clip32(longint'(taps[w][TAP_COUNT_DEF - 1]) + inc);
		acc = 0;
		for (int i = 0; i < TAP_COUNT_DEF; i++)
			acc += longint'(taps[w][i]);
		acc = acc / TAP_COUNT_DEF;
		if (acc > DUTY_MAX)
			acc = DUTY_MAX;
		else if (acc < DUTY_MIN)
			acc = DUTY_MIN;
		duty[w] = acc[DUTY_W-1:0];
	endfunction

	// one accepted beat moves the controller and gives exactly one result
	function automatic ctl_out_t advance_controller(beat_t b);
		longint   err, q;
		ctl_out_t r;
		if (b.cmd == CMD_STEER) begin
			err       = b.steer_error;
			steer_sum = clip32(longint'(steer_sum) + err);
			q = longint'(cfg.steer_kp) * err + longint'(cfg.steer_ki) * longint'(steer_sum)
				+ longint'(cfg.steer_kd) * (err - longint'(steer_last));
			steer_out  = clip32(q / 256);
			steer_last = b.steer_error;
		end else begin
			wheel_step(0, b.left_speed);
			wheel_step(1, b.right_speed);
		end
		r.left_duty    = duty[0];
		r.right_duty   = duty[1];
		r.steer_output = steer_out;
		return r;
	endfunction

	// mostly short gaps, a few long ones, now and then a stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (full_rate)
			return 0;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// unused fields of a beat carry noise, the block must ignore them
	function automatic beat_t speed_beat(int l, int r);
		beat_t b;
		b.cmd         = CMD_SPEED;
		b.left_speed  = SPEED_W'(l);
		b.right_speed = SPEED_W'(r);
		b.steer_error = SPEED_W'($urandom);
		return b;
	endfunction

	function automatic beat_t steer_beat(int e);
		beat_t b;
		b.cmd         = CMD_STEER;
		b.left_speed  = SPEED_W'($urandom);
		b.right_speed = SPEED_W'($urandom);
		b.steer_error = SPEED_W'(e);
		return b;
	endfunction

	// values near a center, with some full-scale noise so every bit toggles
	function automatic int near(int c, int spread);
		if ($urandom_range(0, 99) < 15)
			return int'($urandom);
		return c + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic beat_t random_beat(int center);
		if ($urandom_range(0, 1))
			return speed_beat(near(center, 400), near(center, 400));
		return steer_beat(near(0, 2000));
	endfunction

	// apb write: setup, access, register takes the value at the access edge
	task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_TARGET_SPEED: cfg.target_speed    = val[SPEED_W-1:0];
			REG_SPEED_KP:     cfg.speed_kp        = val[GAIN_W-1:0];
			REG_SPEED_KI:     cfg.speed_ki        = val[GAIN_W-1:0];
			REG_SPEED_KD:     cfg.speed_kd        = val[GAIN_W-1:0];
			REG_STEER_KP:     cfg.steer_kp        = val[GAIN_W-1:0];
			REG_STEER_KI:     cfg.steer_ki        = val[GAIN_W-1:0];
			REG_STEER_KD:     cfg.steer_kd        = val[GAIN_W-1:0];
			REG_COUPLING:     cfg.coupling_enable = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(int tgt, int skp, int ski, int skd,
			int tkp, int tki, int tkd, int coup);
		apb_write(REG_TARGET_SPEED, tgt);
		apb_write(REG_SPEED_KP, skp);
		apb_write(REG_SPEED_KI, ski);
		apb_write(REG_SPEED_KD, skd);
		apb_write(REG_STEER_KP, tkp);
		apb_write(REG_STEER_KI, tki);
		apb_write(REG_STEER_KD, tkd);
		apb_write(REG_COUPLING, coup);
	endtask

	// every beat yields a result, so an empty forecast means the block is idle
	task automatic wait_drained();
		while (beats_to_send.size() != 0 || beat_offered || predicted_out.size() != 0)
			@(posedge clk);
	endtask

	// beat driver: hold the offered beat until taken, then gap or offer the next
	always @(negedge clk) begin
		if (!arst_n) begin
			beat_bus.valid <= 1'b0;
		end else if (!beat_offered) begin
			if (send_gap > 0) begin
				beat_bus.valid <= 1'b0;
				send_gap--;
			end else if (beats_to_send.size() != 0) begin
				beat_bus.cmd         <= beats_to_send[0].cmd;
				beat_bus.left_speed  <= beats_to_send[0].left_speed;
				beat_bus.right_speed <= beats_to_send[0].right_speed;
				beat_bus.steer_error <= beats_to_send[0].steer_error;
				beat_bus.valid       <= 1'b1;
				beat_offered = 1;
			end else begin
				beat_bus.valid <= 1'b0;
			end
		end
	end

	// accepted beat: run the shadow controller and queue its result
	always @(posedge clk) begin
		if (arst_n && beat_bus.valid && beat_bus.ready) begin
			predicted_out.push_back(advance_controller(beats_to_send.pop_front()));
			beat_offered = 0;
			send_gap     = pick_gap(send_calm);
		end
	end

	// result ready: random stalls, plus the long hold-off when asked for
	always @(negedge clk) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_bus.ready <= 1'b0;
			hold_left--;
		end else if (pressure_req) begin
			pressure_req = 0;
			hold_left    = PRESSURE_HOLD - 1;
			out_bus.ready <= 1'b0;
		end else if (sink_stall > 0) begin
			out_bus.ready <= 1'b0;
			sink_stall--;
		end else begin
			out_bus.ready <= 1'b1;
			sink_stall = pick_gap(sink_calm);
		end
	end

	// result monitor: compare against the oldest forecast
	always @(posedge clk) begin
		ctl_out_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (predicted_out.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t unexpected result: left %0d right %0d steer %0d", $time,
						out_bus.left_duty, out_bus.right_duty, out_bus.steer_output);
			end else begin
				want = predicted_out.pop_front();
				if (out_bus.left_duty !== want.left_duty
						|| out_bus.right_duty !== want.right_duty
						|| out_bus.steer_output !== want.steer_output) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display({"%0t result mismatch: expected left %0d right %0d steer %0d,",
							" got left %0d right %0d steer %0d"}, $time,
							want.left_duty, want.right_duty, want.steer_output,
							out_bus.left_duty, out_bus.right_duty, out_bus.steer_output);
				end
			end
		end
	end

	// watchdog: any beat, result or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (beat_bus.valid && beat_bus.ready) || (out_bus.valid && out_bus.ready)
				|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int center;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		beat_bus.valid       = 1'b0;
		beat_bus.cmd         = CMD_STEER;
		beat_bus.left_speed  = '0;
		beat_bus.right_speed = '0;
		beat_bus.steer_error = '0;
		out_bus.ready        = 1'b0;
		cfg        = '0;
		last_err   = '{default: '0};
		err_prev   = '{default: '0};
		taps       = '{default: '{default: '0}};
		duty       = '{default: '0};
		steer_sum  = '0;
		steer_out  = '0;
		steer_last = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: moderate gains with coupling, small and full-scale speeds and errors
		set_config(200, 'h0100, 'h0040, 'h0020, 'h0100, 'h0010, 'h0080, 1);
		beats_to_send.push_back(speed_beat(0, 0));
		beats_to_send.push_back(speed_beat(0, 0));
		beats_to_send.push_back(speed_beat(100, 300));
		beats_to_send.push_back(steer_beat(1000));
		beats_to_send.push_back(speed_beat(200, 200));
		beats_to_send.push_back(steer_beat(-1000));
		beats_to_send.push_back(speed_beat(150, 250));
		beats_to_send.push_back(steer_beat(0));
		beats_to_send.push_back(speed_beat(-1, -1));
		beats_to_send.push_back(steer_beat(32767));
		beats_to_send.push_back(steer_beat(-32768));
		beats_to_send.push_back(speed_beat(-32768, 32767));
		beats_to_send.push_back(speed_beat(32767, -32768));
		beats_to_send.push_back(speed_beat(200, 200));
		wait_drained();

		// directed: every gain at full scale, lowest target, largest error swings
		set_config(-32768, 65535, 65535, 65535, 65535, 65535, 65535, 0);
		beats_to_send.push_back(speed_beat(32767, 32767));
		beats_to_send.push_back(speed_beat(-32768, -32768));
		beats_to_send.push_back(speed_beat(32767, -32768));
		beats_to_send.push_back(steer_beat(32767));
		beats_to_send.push_back(steer_beat(-32768));
		wait_drained();

		// directed: zero gains, highest target, duties must hold
		set_config(32767, 0, 0, 0, 0, 0, 0, 1);
		beats_to_send.push_back(speed_beat(-32768, -32768));
		beats_to_send.push_back(steer_beat(-32768));
		beats_to_send.push_back(speed_beat(0, 0));
		wait_drained();

		// random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: begin
					center = -32768;
					set_config(center, 0, 0, 0, 0, 0, 0, 0);
				end
				2: begin
					center = 32767;
					set_config(center, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535), 1);
				end
				default: begin
					center = int'($urandom_range(0, 600)) - 300;
					set_config(center, $urandom_range(0, 'h300), $urandom_range(0, 'h300),
						$urandom_range(0, 'h300), $urandom_range(0, 'h300),
						$urandom_range(0, 'h40), $urandom_range(0, 'h300),
						(p == 0) ? int'($urandom_range(0, 1)) : int'(p == 4));
				end
			endcase
			repeat (PHASE_BEATS)
				beats_to_send.push_back(random_beat(center));
			// back up the pipeline while the sender keeps offering
			if (p == 2)
				pressure_req = 1;
			wait_drained();
		end

		// saturation sweep at full rate: steer output pinned at the top rail, coupled
		// increments drive the taps to the bottom rail, then a short swing back
		set_config(100, 'h0100, 'h0040, 'h0020, 65535, 65535, 65535, 1);
		full_rate = 1;
		repeat (WIND_UP_BEATS)
			beats_to_send.push_back(steer_beat(32767));
		repeat (20)
			beats_to_send.push_back(speed_beat(near(100, 400), near(100, 400)));
		repeat (WIND_DOWN_BEATS)
			beats_to_send.push_back(steer_beat(-32768));
		repeat (20)
			beats_to_send.push_back(speed_beat(near(100, 400), near(100, 400)));
		wait_drained();
		full_rate = 0;

		// let any stray result show up before the verdict
		repeat (2 * RESULT_LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/dwp_pkg.sv
hw/rtl/dwp_ifs.sv
hw/rtl/dwp_lane.sv
hw/rtl/dwp_steer.sv
hw/rtl/dwp_merge.sv
hw/rtl/dual_wheel_incremental_pid_with_steer.sv
hw/rtl/dwp_checker.sv
dv/dual_wheel_incremental_pid_with_steer_tb.sv
